// File: rtl/isrt_pkg.sv
package isrt_pkg;

	localparam int unsigned VAL_W = 32;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} isrt_ctrl_t;

endpackage

// File: rtl/isrt_cell.sv
module isrt_cell
	import isrt_pkg::*;
(
	input  logic       clk,
	input  isrt_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       at_tail,
	input  val_t       in_value,
	input  logic       left_gt,
	input  val_t       left_value,
	input  val_t       right_value,
	output logic       gt,
	output val_t       value
);

	val_t value_q;

	assign gt    = occupied && (value_q > in_value);
	assign value = value_q;

	// shift left on drain; on insert take left neighbour, the new value, or hold
	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			value_q <= right_value;
		end else if (ctrl.ins) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt || at_tail) begin
				value_q <= in_value;
			end
		end
	end

endmodule

// File: rtl/insertion_sorter.sv
// Requests are taken while idle. After the request marked last, the
// first sorted result shows in the next cycle and one result follows per cycle.
// Throughput: one value per cycle while filling; busy stays high while the stored
// values shift out of the cell chain. The receiver cannot stall.
// Reset (arst_n low): clears the fill count, the overflow flag and the drain state.
module insertion_sorter
	import isrt_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  val_t       item_value,
	input  logic       item_last,
	output logic       strobe,
	output val_t       sorted_value,
	output logic       run_last,
	output logic       overflowed
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic          state_q;
	logic [CW-1:0] count_q;
	logic          drop_q;

	logic          accept;
	logic          full;
	isrt_ctrl_t    ctrl;

	logic [DEPTH-1:0] gt;
	val_t             cell_value [DEPTH];

	assign accept = start && (state_q == ST_IDLE);
	assign full   = (count_q == CW'(DEPTH));
	assign busy   = (state_q == ST_DRAIN);

	assign ctrl.ins   = accept && !full;
	assign ctrl.drain = (state_q == ST_DRAIN);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic occupied;
			logic at_tail;
			logic left_gt;
			val_t left_value;
			val_t right_value;

			assign occupied = (CW'(i) < count_q);
			assign at_tail  = (CW'(i) == count_q);

			if (i == 0) begin : g_head
				assign left_gt    = 1'b0;
				assign left_value = '0;
			end else begin : g_body
				assign left_gt    = gt[i-1];
				assign left_value = cell_value[i-1];
			end

			if (i == DEPTH - 1) begin : g_end
				assign right_value = '0;
			end else begin : g_mid
				assign right_value = cell_value[i+1];
			end

			isrt_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (occupied),
				.at_tail     (at_tail),
				.in_value    (item_value),
				.left_gt     (left_gt),
				.left_value  (left_value),
				.right_value (right_value),
				.gt          (gt[i]),
				.value       (cell_value[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (item_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					count_q <= count_q - CW'(1);
					if (count_q == CW'(1)) begin
						state_q <= ST_IDLE;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe       = (state_q == ST_DRAIN);
	assign sorted_value = cell_value[0];
	assign run_last     = strobe && (count_q == CW'(1));
	assign overflowed   = strobe && drop_q;

`ifndef SYNTHESIS
	a_strobe_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (count_q != '0))
		else $error("result strobe with empty store");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && run_last) |=> (!busy && (count_q == '0) && !drop_q))
		else $error("store not cleared after final result");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !run_last) |=> strobe)
		else $error("sorted run broken off early");

	a_drop_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && full) |=> drop_q)
		else $error("drop on full store not flagged");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item_last) |=> strobe)
		else $error("last request did not start output");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import isrt_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned MAX_CYCLES = 100000;
	localparam int unsigned TARGET_VALUES = 370;

	typedef struct {
		val_t        value;
		logic        last;
		int unsigned gap;
		bit          drain;
	} request_t;

	typedef struct {
		val_t value;
		logic last;
		logic ovf;
	} sorted_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	val_t item_value = '0;
	logic item_last = 1'b0;
	logic strobe;
	val_t sorted_value;
	logic run_last;
	logic overflowed;

	request_t pending[$];
	sorted_t awaited[$];
	sorted_t head;
	val_t sort_store[DEPTH];
	int unsigned store_fill = 0;
	bit store_dropped = 1'b0;
	int unsigned gap_count = 0;
	bit quiet_stretch = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned values_sent = 0;
	int unsigned runs_sent = 0;
	int unsigned ovf_runs = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	always #5 clk = ~clk;

	insertion_sorter #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item_value(item_value),
		.item_last(item_last),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.run_last(run_last),
		.overflowed(overflowed)
	);

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// insert in front of the first strictly greater value; emit the run on last
	task automatic sort_in(val_t v, logic last);
		int unsigned pos;
		pos = store_fill;
		if (store_fill >= DEPTH) begin
			store_dropped = 1'b1;
		end else begin
			for (int unsigned i = 0; i < store_fill; i++)
				if (pos == store_fill && sort_store[i] > v)
					pos = i;
			for (int unsigned i = store_fill; i > pos; i--)
				sort_store[i] = sort_store[i - 1];
			sort_store[pos] = v;
			store_fill++;
		end
		if (last) begin
			for (int unsigned k = 0; k < store_fill; k++)
				awaited.push_back('{sort_store[k], logic'(k + 1 == store_fill),
					logic'(store_dropped)});
			runs_sent++;
			if (store_dropped)
				ovf_runs++;
			store_fill = 0;
			store_dropped = 1'b0;
		end
	endtask

	function automatic int unsigned draw_gap();
		return quiet_stretch ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic val_t draw_value(int unsigned mode);
		case (mode)
			0: return val_t'($urandom);
			1: return val_t'(int'($urandom_range(0, 8)) - 4);
			default: begin
				case ($urandom_range(0, 6))
					0: return 32'sh8000_0000;
					1: return 32'sh8000_0001;
					2: return 32'sh7fff_ffff;
					3: return 32'sh7fff_fffe;
					4: return -32'sd1;
					5: return 32'sd1;
					default: return 32'sd0;
				endcase
			end
		endcase
	endfunction

	task automatic queue_request(val_t v, logic last, bit drain);
		pending.push_back('{v, last, draw_gap(), drain});
	endtask

	task automatic queue_run(int unsigned len, int unsigned mode, bit drain);
		for (int unsigned i = 0; i < len; i++)
			queue_request(draw_value(mode), logic'(i + 1 == len), drain && i == 0);
	endtask

	// present the next request once the port is free, its gap has passed and, for a drain request, no results are awaited
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sort_in(item_value, item_last);
				values_sent++;
			end
			if (!start || !busy) begin
				if (pending.size() == 0) begin
					start <= 1'b0;
				end else if (gap_count < pending[0].gap ||
						(pending[0].drain && awaited.size() != 0)) begin
					gap_count++;
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					item_value <= pending[0].value;
					item_last <= pending[0].last;
					void'(pending.pop_front());
					gap_count = 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d last=%b ovf=%b",
					sorted_value, run_last, overflowed));
			end else begin
				head = awaited.pop_front();
				if (sorted_value !== head.value)
					report_mismatch($sformatf("sorted_value %0d, want %0d",
						sorted_value, head.value));
				if (run_last !== head.last)
					report_mismatch($sformatf("run_last %b, want %b", run_last, head.last));
				if (overflowed !== head.ovf)
					report_mismatch($sformatf("overflowed %b, want %b",
						overflowed, head.ovf));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		int unsigned run_idx;
		run_idx = 0;

		queue_request(32'sh8000_0000, 1'b1, 1'b1);
		queue_request(32'sh7fff_ffff, 1'b1, 1'b0);
		queue_request(32'sh7fff_ffff, 1'b0, 1'b0);
		queue_request(32'sh8000_0000, 1'b0, 1'b0);
		queue_request(32'sd0, 1'b0, 1'b0);
		queue_request(-32'sd1, 1'b0, 1'b0);
		queue_request(32'sd1, 1'b1, 1'b0);
		// fill the store, then drop one plain request and one marked last
		queue_run(DEPTH, 0, 1'b1);
		pending[pending.size() - 1].last = 1'b0;
		queue_request(draw_value(0), 1'b0, 1'b0);
		queue_request(draw_value(2), 1'b1, 1'b0);

		while (pending.size() < TARGET_VALUES) begin
			if ($urandom_range(0, 3) == 0)
				quiet_stretch = !quiet_stretch;
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(DEPTH - 2, DEPTH + 4);
			else
				len = $urandom_range(1, 8);
			queue_run(len, $urandom_range(0, 2), run_idx % 5 == 0);
			run_idx++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending.size() != 0 || start || awaited.size() != 0);
		repeat (DEPTH + 4) @(posedge clk);

		$display("Sent %0d values in %0d runs, %0d of them overflowing the store;",
			values_sent, runs_sent, ovf_runs);
		$display("checked %0d sorted results field by field.", results_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
